// ----- src/fcle_pkg.sv -----
// Package for the fixed-capacity list engine: command and status codes,
// plus the command and status bundles between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package fcle_pkg;

   // Command codes carried by the request word.
   localparam logic [2:0] CMD_APPEND = 3'd0;
   localparam logic [2:0] CMD_GET    = 3'd1;
   localparam logic [2:0] CMD_SET    = 3'd2;
   localparam logic [2:0] CMD_CLEAR  = 3'd3;
   localparam logic [2:0] CMD_FIND   = 3'd4;
   localparam logic [2:0] CMD_COUNT  = 3'd5;
   localparam logic [2:0] CMD_DELETE = 3'd6;

   // Status codes carried by the response word.
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;

   // Reset value of the entry limit register.
   localparam logic [8:0] LIMIT_RESET = 9'd256;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch_req;   // capture the request word, clear the result fields
      logic append_wr;   // write the value at the tail and grow the list
      logic clr_size;    // empty the list
      logic dec_size;    // shrink the list by one
      logic mark_full;   // flag a refused append
      logic mark_range;  // flag a bad index
      logic rd_pos;      // read the entry at the requested position
      logic capture_rd;  // take the read data; a set also writes the new value
      logic scan_init;   // start a walk over the store
      logic scan_run;    // keep the walk going
      logic load_rsp;    // load the response register
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [2:0] cmd;
      logic       in_range;
      logic       can_append;
      logic       scan_more;
      logic       pend;
      logic       rsp_busy;
   } dp_stat_type;

endpackage

// ----- src/fcle_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module fcle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/fcle_ctrl.sv -----
// Controller state machine for the list engine: sequences one request word
// at a time through decode, store access or a store walk, and response load.
// Depends on fcle_pkg.
`timescale 1ns / 1ps

module fcle_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  fcle_pkg::dp_stat_type stat,
   output fcle_pkg::dp_cmd_type  cmd
);
   import fcle_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_DECODE  = 5'b00010,
      ST_WAIT_RD = 5'b00100,
      ST_SCAN    = 5'b01000,
      ST_FINISH  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_FINISH;
            case (stat.cmd)
               CMD_APPEND: begin
                  if (stat.can_append) begin
                     cmd.append_wr = 1'b1;
                  end else begin
                     cmd.mark_full = 1'b1;
                  end
               end
               CMD_GET, CMD_SET: begin
                  if (stat.in_range) begin
                     cmd.rd_pos = 1'b1;
                     state_in   = ST_WAIT_RD;
                  end else begin
                     cmd.mark_range = 1'b1;
                  end
               end
               CMD_CLEAR: begin
                  cmd.clr_size = 1'b1;
               end
               CMD_FIND, CMD_COUNT: begin
                  cmd.scan_init = 1'b1;
                  state_in      = ST_SCAN;
               end
               CMD_DELETE: begin
                  if (stat.in_range) begin
                     cmd.scan_init = 1'b1;
                     state_in      = ST_SCAN;
                  end else begin
                     cmd.mark_range = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_WAIT_RD: begin
            cmd.capture_rd = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_SCAN: begin
            // The walk ends once no read is left to issue or to consume.
            if (!stat.scan_more && !stat.pend) begin
               cmd.dec_size = (stat.cmd == CMD_DELETE);
               state_in     = ST_FINISH;
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         ST_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- src/fcle_datapath.sv -----
// Datapath for the list engine: request registers, size and limit registers,
// the entry store, the walk counter, the result fields and the response register.
// Depends on fcle_pkg and fcle_ram.
`timescale 1ns / 1ps

module fcle_datapath #(
   parameter int DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fcle_pkg::dp_cmd_type  cmd,
   output fcle_pkg::dp_stat_type stat,
   input  logic [2:0]            req_command,
   input  logic [7:0]            req_position,
   input  logic signed [31:0]    req_value_in,
   input  logic                  csr_valid,
   input  logic [8:0]            csr_limit_entries,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic signed [31:0]    rsp_value_out,
   output logic                  rsp_found,
   output logic [7:0]            rsp_found_position,
   output logic [8:0]            rsp_match_count,
   output logic [8:0]            rsp_size_out
);
   import fcle_pkg::*;

   localparam int AW = $clog2(DEPTH);
   // Largest size the 9-bit size register can reach in this store.
   localparam logic [8:0] DEPTH_CAP = (DEPTH > 511) ? 9'd511 : 9'(DEPTH);

   logic [2:0]  cmd_ff;
   logic [7:0]  pos_ff;
   logic [31:0] val_ff;
   logic [8:0]  size_ff;
   logic [8:0]  limit_ff;
   logic [8:0]  scan_idx_ff;
   logic        pend_ff;
   logic [8:0]  pend_idx_ff;
   logic [1:0]  status_ff;
   logic [31:0] vout_ff;
   logic        found_ff;
   logic [7:0]  fpos_ff;
   logic [8:0]  cnt_ff;
   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_value_ff;
   logic        rsp_found_ff;
   logic [7:0]  rsp_fpos_ff;
   logic [8:0]  rsp_cnt_ff;
   logic [8:0]  rsp_size_ff;

   logic [8:0]    eff_limit;
   logic          scan_more;
   logic          match;
   logic          set_wr;
   logic          del_wr;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [31:0]   ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [31:0]   ram_rd_data;

   // Limits and range checks.
   assign eff_limit = (limit_ff > DEPTH_CAP) ? DEPTH_CAP : limit_ff;
   assign scan_more = (scan_idx_ff < size_ff);
   assign match     = (ram_rd_data == val_ff);

   assign stat.cmd        = cmd_ff;
   assign stat.in_range   = ({1'b0, pos_ff} < size_ff);
   assign stat.can_append = (size_ff < eff_limit);
   assign stat.scan_more  = scan_more;
   assign stat.pend       = pend_ff;
   assign stat.rsp_busy   = rsp_valid_ff && !rsp_ready;

   // Store port selection. A delete moves the entry read last cycle down by one.
   assign set_wr    = cmd.capture_rd && (cmd_ff == CMD_SET);
   assign del_wr    = pend_ff && (cmd_ff == CMD_DELETE);
   assign ram_wr_en = cmd.append_wr || set_wr || del_wr;
   assign ram_rd_en = cmd.rd_pos || (cmd.scan_run && scan_more);

   always_comb begin
      if (cmd.append_wr) begin
         ram_wr_addr = AW'(size_ff);
         ram_wr_data = val_ff;
      end else if (set_wr) begin
         ram_wr_addr = AW'(pos_ff);
         ram_wr_data = val_ff;
      end else begin
         ram_wr_addr = AW'(pend_idx_ff - 9'd1);
         ram_wr_data = ram_rd_data;
      end
   end

   assign ram_rd_addr = cmd.rd_pos ? AW'(pos_ff) : AW'(scan_idx_ff);

   fcle_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Request word capture.
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         cmd_ff <= req_command;
         pos_ff <= req_position;
         val_ff <= req_value_in;
      end
   end

   // Size and limit registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= '0;
         limit_ff <= LIMIT_RESET;
      end else begin
         if (csr_valid) begin
            limit_ff <= csr_limit_entries;
         end
         if (cmd.clr_size) begin
            size_ff <= '0;
         end else if (cmd.append_wr) begin
            size_ff <= size_ff + 9'd1;
         end else if (cmd.dec_size) begin
            size_ff <= size_ff - 9'd1;
         end
      end
   end

   // Walk counter: one read issued per cycle, consumed the cycle after.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.scan_run && scan_more;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         scan_idx_ff <= (cmd_ff == CMD_DELETE) ? ({1'b0, pos_ff} + 9'd1) : 9'd0;
      end else if (cmd.scan_run && scan_more) begin
         scan_idx_ff <= scan_idx_ff + 9'd1;
      end
      pend_idx_ff <= scan_idx_ff;
   end

   // Result fields of the current command.
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         status_ff <= STAT_OK;
         vout_ff   <= '0;
         found_ff  <= 1'b0;
         fpos_ff   <= '0;
         cnt_ff    <= '0;
      end else begin
         if (cmd.mark_full) begin
            status_ff <= STAT_FULL;
         end else if (cmd.mark_range) begin
            status_ff <= STAT_RANGE;
         end
         if (cmd.capture_rd) begin
            vout_ff <= ram_rd_data;
         end
         if (pend_ff && match && (cmd_ff == CMD_FIND) && !found_ff) begin
            found_ff <= 1'b1;
            fpos_ff  <= pend_idx_ff[7:0];
         end
         if (pend_ff && match && (cmd_ff == CMD_COUNT)) begin
            cnt_ff <= cnt_ff + 9'd1;
         end
      end
   end

   // Response register; a new word is loaded only once the last one is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_value_ff  <= vout_ff;
         rsp_found_ff  <= found_ff;
         rsp_fpos_ff   <= fpos_ff;
         rsp_cnt_ff    <= cnt_ff;
         rsp_size_ff   <= size_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_value_out      = rsp_value_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_match_count    = rsp_cnt_ff;
   assign rsp_size_out       = rsp_size_ff;

endmodule

// ----- src/fixed_capacity_list_engine.sv -----
// Channel  Handshake              Payload
// req      req_valid/req_ready    req_command, req_position, req_value_in
// rsp      rsp_valid/rsp_ready    rsp_status, rsp_value_out, rsp_found,
//                                 rsp_found_position, rsp_match_count, rsp_size_out
// csr      csr_valid/csr_ready    csr_limit_entries
//
// One request word is worked at a time. Get and set make one registered store read;
// find, count and delete walk the store through its one read port, which the walk
// uses once per cycle. A new word is accepted while the last response still waits;
// the next response then holds in the finish state until that one is taken. Reset
// empties the list and sets the limit to 256; the store itself is not cleared. The
// csr port is always ready.
// Top level of the list engine; depends on fcle_pkg, fcle_ctrl and fcle_datapath.
`timescale 1ns / 1ps

module fixed_capacity_list_engine #(
   parameter int DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_command,
   input  logic [7:0]         req_position,
   input  logic signed [31:0] req_value_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_value_out,
   output logic               rsp_found,
   output logic [7:0]         rsp_found_position,
   output logic [8:0]         rsp_match_count,
   output logic [8:0]         rsp_size_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [8:0]         csr_limit_entries
);
   import fcle_pkg::*;

   localparam logic [8:0] SIZE_CAP = (DEPTH > 511) ? 9'd511 : 9'(DEPTH);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   assign csr_ready = 1'b1;

   fcle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   fcle_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (dp_cmd),
      .stat               (dp_stat),
      .req_command        (req_command),
      .req_position       (req_position),
      .req_value_in       (req_value_in),
      .csr_valid          (csr_valid),
      .csr_limit_entries  (csr_limit_entries),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_value_out      (rsp_value_out),
      .rsp_found          (rsp_found),
      .rsp_found_position (rsp_found_position),
      .rsp_match_count    (rsp_match_count),
      .rsp_size_out       (rsp_size_out)
   );

   // The list never grows past what the store can hold.
   a_size_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_size_out <= SIZE_CAP))
      else $error("list size beyond store capacity");

   // A miss reports no position.
   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_found_position == 8'd0))
      else $error("found position set without a hit");

   // A refused command reports no value and no count.
   a_refused_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STAT_OK)) |->
         ((rsp_value_out == 32'sd0) && (rsp_match_count == 9'd0) && !rsp_found))
      else $error("refused command carries result data");

   // Only one word is in work at a time.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in work");

endmodule
